// ===== rtl/core/ids_pkg.sv =====
// ----------------------------------------------------------------------------
// ids_pkg
// Shared constants and types of the 2x2 image downsampler.
// ----------------------------------------------------------------------------
package ids_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALVE_X      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HALVE_Y      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REDUCE_MODE  = 3'd4;

  // reduce modes; the unused codes act as top-left
  localparam logic [2:0] MODE_AVG      = 3'd0;
  localparam logic [2:0] MODE_TOP_LEFT = 3'd1;
  localparam logic [2:0] MODE_BOT_RGT  = 3'd2;
  localparam logic [2:0] MODE_MAX      = 3'd3;
  localparam logic [2:0] MODE_MIN      = 3'd4;

  // register reset values
  localparam logic [CFG_DATA_W-1:0] RST_IMAGE_WIDTH  = 13'd64;
  localparam logic [CFG_DATA_W-1:0] RST_IMAGE_HEIGHT = 13'd64;
  localparam logic [2:0]            RST_REDUCE_MODE  = MODE_AVG;

  // row counter covers the largest supported height
  localparam int MAX_HEIGHT = 4096;
  localparam int ROW_W      = 12;

  // reduction settings seen by the arithmetic stage
  typedef struct packed {
    logic       halve_x;
    logic       halve_y;
    logic [2:0] mode;
  } ids_mode_t;

  // per-pixel window flags from the position counters
  typedef struct packed {
    logic emit;
    logic row_end;
    logic frame_end;
  } ids_flags_t;

endpackage

// ===== rtl/core/ids_stream_if.sv =====
// ----------------------------------------------------------------------------
// ids_in_if / ids_out_if
// Valid/ready pixel channels of the 2x2 image downsampler.
// ----------------------------------------------------------------------------
interface ids_in_if #(
  parameter int W = 16
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface ids_out_if #(
  parameter int W = 16
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] pixel_out;
  logic                row_end;
  logic                frame_end;

  modport source (output valid, output pixel_out, output row_end, output frame_end,
                  input ready);
  modport sink   (input valid, input pixel_out, input row_end, input frame_end,
                  output ready);
endinterface

// ===== rtl/core/ids_ctrl.sv =====
// ----------------------------------------------------------------------------
// ids_ctrl
// Configuration registers and raster position counters; derives the window
// flags and the line store write enable for each incoming pixel.
// ----------------------------------------------------------------------------
module ids_ctrl
  import ids_pkg::*;
#(
  parameter int MAX_WIDTH = 4096,
  parameter int AW        = $clog2(MAX_WIDTH)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  accept_i,
  output logic [AW-1:0]         col_o,
  output logic                  store_we_o,
  output ids_flags_t            flags_o,
  output ids_mode_t             mode_o
);

  logic [CFG_DATA_W-1:0] width_q, height_q;
  logic                  halve_x_q, halve_y_q;
  logic [2:0]            mode_q;
  logic [AW-1:0]         col_q, col_d;
  logic [ROW_W-1:0]      row_q, row_d;
  logic [AW-1:0]         wlast;
  logic [ROW_W-1:0]      hlast;
  logic                  cfg_hit;
  logic                  col_end, row_last;

  // last column / row index after clamping the raw size registers
  always_comb begin
    if (width_q == '0) begin
      wlast = '0;
    end else if (32'(width_q) > MAX_WIDTH) begin
      wlast = AW'(MAX_WIDTH - 1);
    end else begin
      wlast = AW'(width_q - 13'd1);
    end
    if (height_q == '0) begin
      hlast = '0;
    end else if (32'(height_q) > MAX_HEIGHT) begin
      hlast = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      hlast = ROW_W'(height_q - 13'd1);
    end
  end

  assign cfg_hit = cfg_we_i && (cfg_idx_i inside {CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT,
                                                   CFG_HALVE_X, CFG_HALVE_Y,
                                                   CFG_REDUCE_MODE});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= RST_IMAGE_WIDTH;
      height_q  <= RST_IMAGE_HEIGHT;
      halve_x_q <= 1'b1;
      halve_y_q <= 1'b1;
      mode_q    <= RST_REDUCE_MODE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IMAGE_WIDTH:  width_q   <= cfg_data_i;
        CFG_IMAGE_HEIGHT: height_q  <= cfg_data_i;
        CFG_HALVE_X:      halve_x_q <= cfg_data_i[0];
        CFG_HALVE_Y:      halve_y_q <= cfg_data_i[0];
        CFG_REDUCE_MODE:  mode_q    <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  assign col_end  = (col_q == wlast);
  assign row_last = (row_q == hlast);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_hit) begin
      // any register write restarts the frame
      col_d = '0;
      row_d = '0;
    end else if (accept_i) begin
      if (col_end) begin
        col_d = '0;
        row_d = row_last ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // on a halved axis only odd positions close a window; the last odd position
  // is the last index for an even size and the one before it for an odd size
  always_comb begin
    flags_o.emit = (!halve_x_q || col_q[0]) && (!halve_y_q || row_q[0]);
    flags_o.row_end = halve_x_q ? (col_end || (AW'(col_q + 1'b1) == wlast)) : col_end;
    flags_o.frame_end = flags_o.row_end &&
                        (halve_y_q ? (row_last || (ROW_W'(row_q + 1'b1) == hlast))
                                   : row_last);
  end

  assign col_o      = col_q;
  assign store_we_o = halve_y_q && !row_q[0];
  assign mode_o     = '{halve_x: halve_x_q, halve_y: halve_y_q, mode: mode_q};

endmodule

// ===== rtl/core/ids_line_store.sv =====
// ----------------------------------------------------------------------------
// ids_line_store
// Single-port line memory holding the even source row, registered read.
// ----------------------------------------------------------------------------
module ids_line_store #(
  parameter int DEPTH = 4096,
  parameter int W     = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic [W-1:0]  wdata_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/ids_reduce.sv =====
// ----------------------------------------------------------------------------
// ids_reduce
// Window stage and output register: assembles the window from the line
// store read, the previous read and the left pixel, and reduces it.
// ----------------------------------------------------------------------------
module ids_reduce
  import ids_pkg::*;
#(
  parameter int PIXEL_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic signed [PIXEL_BITS-1:0] pixel_i,
  input  ids_flags_t                   flags_i,
  input  ids_mode_t                    mode_i,
  input  logic signed [PIXEL_BITS-1:0] rd_data_i,
  output logic                         in_ready_o,
  output logic                         accept_o,
  ids_out_if.source                    out_o
);

  localparam int S4 = PIXEL_BITS + 2;
  localparam int S2 = PIXEL_BITS + 1;

  logic                         s1_v_q;
  logic signed [PIXEL_BITS-1:0] s1_pix_q, s1_left_q, s1_tprev_q;
  ids_flags_t                   s1_flags_q;
  logic signed [PIXEL_BITS-1:0] left_q;
  logic                         out_v_q;
  logic signed [PIXEL_BITS-1:0] out_pix_q;
  logic                         out_re_q, out_fe_q;
  logic                         out_free;

  logic signed [PIXEL_BITS-1:0] wa, wb, wc, wd, oa, ob;
  logic signed [PIXEL_BITS-1:0] max_ab, max_cd, min_ab, min_cd, res;
  logic signed [S4-1:0]         sum4, sum4_adj;
  logic signed [S2-1:0]         sum2, sum2_adj;

  assign out_free   = !out_v_q || out_o.ready;
  assign in_ready_o = !s1_v_q || out_free;
  assign accept_o   = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      left_q  <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_v_q <= accept_o;
      end
      if (accept_o) begin
        left_q <= pixel_i;
      end
      if (out_free) begin
        out_v_q <= s1_v_q && s1_flags_q.emit;
      end
    end
  end

  // rd_data_i still shows the previous request's read at the accept edge
  always_ff @(posedge clk_i) begin
    if (accept_o) begin
      s1_pix_q   <= pixel_i;
      s1_left_q  <= left_q;
      s1_tprev_q <= rd_data_i;
      s1_flags_q <= flags_i;
    end
  end

  // 2x2 window: a top-left, b top-right, c bottom-left, d bottom-right
  assign wa = s1_tprev_q;
  assign wb = rd_data_i;
  assign wc = s1_left_q;
  assign wd = s1_pix_q;
  // one-axis window: first pixel from the left or from the row above
  assign oa = mode_i.halve_x ? s1_left_q : rd_data_i;
  assign ob = s1_pix_q;

  always_comb begin
    sum4     = S4'(wa) + S4'(wb) + S4'(wc) + S4'(wd);
    // bias negative sums so the shift truncates toward zero
    sum4_adj = sum4 + $signed({{PIXEL_BITS{1'b0}}, sum4[S4-1], sum4[S4-1]});
    sum2     = S2'(oa) + S2'(ob);
    sum2_adj = sum2 + $signed({{PIXEL_BITS{1'b0}}, sum2[S2-1]});
    max_ab   = (wa > wb) ? wa : wb;
    max_cd   = (wc > wd) ? wc : wd;
    min_ab   = (wa < wb) ? wa : wb;
    min_cd   = (wc < wd) ? wc : wd;
    res      = s1_pix_q;
    if (mode_i.halve_x && mode_i.halve_y) begin
      case (mode_i.mode)
        MODE_AVG:     res = PIXEL_BITS'(sum4_adj >>> 2);
        MODE_BOT_RGT: res = wd;
        MODE_MAX:     res = (max_ab > max_cd) ? max_ab : max_cd;
        MODE_MIN:     res = (min_ab < min_cd) ? min_ab : min_cd;
        default:      res = wa;
      endcase
    end else if (mode_i.halve_x || mode_i.halve_y) begin
      case (mode_i.mode)
        MODE_AVG:     res = PIXEL_BITS'(sum2_adj >>> 1);
        MODE_BOT_RGT: res = ob;
        MODE_MAX:     res = (oa > ob) ? oa : ob;
        MODE_MIN:     res = (oa < ob) ? oa : ob;
        default:      res = oa;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s1_v_q) begin
      out_pix_q <= res;
      out_re_q  <= s1_flags_q.row_end;
      out_fe_q  <= s1_flags_q.frame_end;
    end
  end

  assign out_o.valid     = out_v_q;
  assign out_o.pixel_out = out_pix_q;
  assign out_o.row_end   = out_re_q;
  assign out_o.frame_end = out_fe_q;

endmodule

// ===== rtl/core/image_downsample_2x2.sv =====
// An accepted pixel is held in the window stage, then in the output register.
// Throughput: one pixel per cycle unless the output stalls; the line store
// does one read and at most one write per accepted pixel, at its column, and
// one request can enter the window stage while a finished result waits to be
// taken. Reset: counters return to the frame start and registers to their
// defaults; the store is not cleared, and its data is only used once written.
// ----------------------------------------------------------------------------
// image_downsample_2x2
// Streaming 2x2 / 2x1 / 1x2 (or 1x1) image reducer with a one-row line store.
// ----------------------------------------------------------------------------
module image_downsample_2x2
  import ids_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int PIXEL_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  ids_in_if.sink                in_i,
  ids_out_if.source             out_o
);

  localparam int AW = $clog2(MAX_WIDTH);

  logic                         accept;
  logic [AW-1:0]                col;
  logic                         store_we;
  ids_flags_t                   flags;
  ids_mode_t                    mode;
  logic signed [PIXEL_BITS-1:0] rd_data;
  logic [PIXEL_BITS-1:0]        rd_raw;

  ids_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .col_o      (col),
    .store_we_o (store_we),
    .flags_o    (flags),
    .mode_o     (mode)
  );

  ids_line_store #(
    .DEPTH (MAX_WIDTH),
    .W     (PIXEL_BITS),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .en_i    (accept),
    .we_i    (store_we),
    .addr_i  (col),
    .wdata_i (in_i.pixel_in),
    .rdata_o (rd_raw)
  );

  assign rd_data = $signed(rd_raw);

  ids_reduce #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_reduce (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .pixel_i    (in_i.pixel_in),
    .flags_i    (flags),
    .mode_i     (mode),
    .rd_data_i  (rd_data),
    .in_ready_o (in_i.ready),
    .accept_o   (accept),
    .out_o      (out_o)
  );

endmodule

// ===== rtl/core/ids_checker.sv =====
// ----------------------------------------------------------------------------
// ids_checker
// Port-level checks of the 2x2 image downsampler, bound to the top level.
// ----------------------------------------------------------------------------
module ids_checker #(
  parameter int PIXEL_BITS = 16
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic [PIXEL_BITS-1:0] out_pixel_i,
  input logic                  out_row_end_i,
  input logic                  out_frame_end_i
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_pixel_i) &&
    $stable(out_row_end_i) && $stable(out_frame_end_i))
    else $error("ids: stalled result changed");

  // the last pixel of a frame also closes its row
  a_frame_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_frame_end_i |-> out_row_end_i)
    else $error("ids: frame_end without row_end");

  // input backpressure only comes from a full, stalled output
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("ids: input stalled with output free");

  // a fresh result follows an accepted request
  a_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("ids: result without request");

endmodule

bind image_downsample_2x2 ids_checker #(
  .PIXEL_BITS (PIXEL_BITS)
) u_ids_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_pixel_i     (out_o.pixel_out),
  .out_row_end_i   (out_o.row_end),
  .out_frame_end_i (out_o.frame_end)
);
